>>> src/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and constants of the COBS frame decoder.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;

  localparam logic [ByteW-1:0] FullCode   = 8'hFF;
  localparam logic [LenW-1:0]  MaxLenRst  = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_CAP   = 2'd2
  } frame_status_e;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } result_kind_e;

  // One result as it travels from the decode step to the output register.
  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] data_byte;
    logic [1:0]       frame_status;
    logic [LenW-1:0]  frame_len;
  } result_t;

endpackage

>>> src/cfd_if.sv
// ----------------------------------------------------------------------------
// cfd_if
// Valid/ready channels of the COBS frame decoder: encoded bytes in, results out.
// ----------------------------------------------------------------------------
interface cfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface cfd_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [1:0]  frame_status;
  logic [15:0] frame_len;

  modport source (output valid, output kind, output data_byte, output frame_status,
                  output frame_len, input ready);
  modport sink   (input valid, input kind, input data_byte, input frame_status,
                  input frame_len, output ready);
endinterface

>>> src/cfd_in_reg.sv
// ----------------------------------------------------------------------------
// cfd_in_reg
// Input register: holds one encoded byte until the decode step consumes it.
// ----------------------------------------------------------------------------
module cfd_in_reg
  import cfd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             advance_i,
  output logic             valid_o,
  output logic [ByteW-1:0] byte_o
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             take;

  // A slot is free when empty or when its byte moves on in this cycle.
  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (take) begin
      valid_d = 1'b1;
      byte_d  = in_byte_i;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

>>> src/cfd_step.sv
// ----------------------------------------------------------------------------
// cfd_step
// Decode step: frame state, capacity register and the result of one byte.
// ----------------------------------------------------------------------------
module cfd_step
  import cfd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LenW-1:0]  cfg_wdata_i,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  output logic             has_result_o,
  output result_t          result_o
);

  logic [LenW-1:0]  max_len_q, max_len_d;
  logic [ByteW-1:0] group_left_q, group_left_d;
  logic             have_group_q, have_group_d;
  logic             last_full_q, last_full_d;
  logic [LenW-1:0]  out_count_q, out_count_d;
  logic [1:0]       err_q, err_d;

  logic             is_term, is_code, want_emit, emit_ok, room;
  logic [ByteW-1:0] emit_val;
  logic [1:0]       status;

  assign is_term = (byte_i == '0);
  assign is_code = (group_left_q == '0);
  assign room    = (out_count_q < max_len_q);

  always_comb begin
    want_emit = 1'b0;
    emit_val  = '0;
    if (!is_term) begin
      if (is_code) begin
        // The zero owed by the previous short group goes out now.
        want_emit = have_group_q && !last_full_q;
      end else begin
        want_emit = 1'b1;
        emit_val  = byte_i;
      end
    end
  end

  assign emit_ok = want_emit && (err_q == ST_OK) && room;

  always_comb begin
    status = err_q;
    if (err_q == ST_OK && !is_code) begin
      status = ST_TRUNC;
    end
  end

  always_comb begin
    has_result_o = is_term || emit_ok;
    result_o     = '0;
    if (is_term) begin
      result_o.kind         = KIND_STATUS;
      result_o.frame_status = status;
      result_o.frame_len    = out_count_q;
    end else begin
      result_o.kind      = KIND_DATA;
      result_o.data_byte = emit_val;
    end
  end

  always_comb begin
    max_len_d    = cfg_we_i ? cfg_wdata_i : max_len_q;
    group_left_d = group_left_q;
    have_group_d = have_group_q;
    last_full_d  = last_full_q;
    out_count_d  = out_count_q;
    err_d        = err_q;
    if (step_i) begin
      if (is_term) begin
        group_left_d = '0;
        have_group_d = 1'b0;
        last_full_d  = 1'b0;
        out_count_d  = '0;
        err_d        = ST_OK;
      end else begin
        if (is_code) begin
          group_left_d = byte_i - ByteW'(1);
          have_group_d = 1'b1;
          last_full_d  = (byte_i == FullCode);
        end else begin
          group_left_d = group_left_q - ByteW'(1);
        end
        if (emit_ok) begin
          out_count_d = out_count_q + LenW'(1);
        end else if (want_emit && err_q == ST_OK) begin
          err_d = ST_CAP;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q    <= MaxLenRst;
      group_left_q <= '0;
      have_group_q <= 1'b0;
      last_full_q  <= 1'b0;
      out_count_q  <= '0;
      err_q        <= ST_OK;
    end else begin
      max_len_q    <= max_len_d;
      group_left_q <= group_left_d;
      have_group_q <= have_group_d;
      last_full_q  <= last_full_d;
      out_count_q  <= out_count_d;
      err_q        <= err_d;
    end
  end

endmodule

>>> src/cfd_out_reg.sv
// ----------------------------------------------------------------------------
// cfd_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module cfd_out_reg
  import cfd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = result_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

>>> src/cobs_frame_decoder.sv
// ----------------------------------------------------------------------------
// cobs_frame_decoder
// Streaming COBS decoder: one encoded byte in per item, at most one result out.
// ----------------------------------------------------------------------------
// Usage: encoded bytes arrive on in_i, a valid/ready channel with one byte per
// item; a zero byte ends the frame. Results leave on out_o. A data result
// (kind 0) carries one decoded byte. A status result (kind 1) closes every
// frame and carries the frame status (ok, group cut short, capacity exceeded)
// and the count of decoded bytes sent. Literals and code bytes that emit
// nothing consume their item without producing a result.
// The capacity register is written through max_out_len_we_i and max_out_len_i
// while the decoder is idle; the user must keep to this, as the block itself
// does not enforce it. It resets to 65535. A byte accepted into the input
// register is decoded there by the decode step, which loads its result into
// the output register once that register can take it. Throughput is one item
// per cycle unless a byte with a result waits on a stalled receiver, set by
// the combinational decode step and its registered frame state update.
// When the receiver stalls, the output register holds its result and the
// input register still drains bytes that produce no result; a byte that does
// produce one waits, and in_i deasserts ready once the input register is full.
// Reset empties both registers, clears the frame state and restores the
// capacity register.
// ----------------------------------------------------------------------------
module cobs_frame_decoder
  import cfd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            max_out_len_we_i,
  input  logic [LenW-1:0] max_out_len_i,
  cfd_byte_if.sink        in_i,
  cfd_result_if.source    out_o
);

  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             has_result;
  logic             out_valid;
  logic             advance;
  logic             load;
  result_t          step_res;
  result_t          out_res;

  cfd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_byte_i  (in_i.byte_in),
    .advance_i  (advance),
    .valid_o    (in_valid),
    .byte_o     (in_byte)
  );

  // The held byte is decoded when it produces no result, or when the output
  // register is empty or is being emptied in this cycle.
  assign advance = in_valid && (!has_result || !out_valid || out_o.ready);
  assign load    = advance && has_result;

  cfd_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (max_out_len_we_i),
    .cfg_wdata_i  (max_out_len_i),
    .step_i       (advance),
    .byte_i       (in_byte),
    .has_result_o (has_result),
    .result_o     (step_res)
  );

  cfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .result_i    (step_res),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .result_o    (out_res)
  );

  assign out_o.valid        = out_valid;
  assign out_o.kind         = out_res.kind;
  assign out_o.data_byte    = out_res.data_byte;
  assign out_o.frame_status = out_res.frame_status;
  assign out_o.frame_len    = out_res.frame_len;

endmodule
